[rtl/packed_field_array_access_core_macros.svh]
// Assertion macros for the packed field array access core.
// Used by the RTL files that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef PACKED_FIELD_ARRAY_ACCESS_CORE_MACROS_SVH
`define PACKED_FIELD_ARRAY_ACCESS_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PFAA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PFAA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/pfaa_pkg.sv]
// Shared constants and types for the packed field array access core.
// No dependencies.
`default_nettype none

package pfaa_pkg;

    localparam int STORE_WORDS = 1024;
    localparam int WORD_BITS   = 64;
    localparam int OFF_W       = $clog2(WORD_BITS);
    localparam int PAIR_W      = 2 * WORD_BITS;
    localparam int BANK_WORDS  = (STORE_WORDS + 1) / 2;
    localparam int BANK_AW     = (BANK_WORDS > 1) ? $clog2(BANK_WORDS) : 1;

    localparam int INDEX_W = 16;
    localparam int EW_W    = 5;
    localparam int EC_W    = 17;
    localparam int VAL_W   = 31;
    localparam int POS_W   = INDEX_W + EW_W;

    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int REG_IDX_LSB = 2;

    localparam logic [EW_W-1:0] ENTRY_WIDTH_RESET = EW_W'(4);
    localparam logic [EC_W-1:0] ENTRY_COUNT_RESET = EC_W'(4096);

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef enum logic [0:0] {
        REG_ENTRY_WIDTH = 1'b0,
        REG_ENTRY_COUNT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic               err;
        logic               straddle;
        logic               lo_odd;
        logic [OFF_W-1:0]   off;
        logic [BANK_AW-1:0] even_addr;
        logic [BANK_AW-1:0] odd_addr;
    } loc_t;

endpackage

`default_nettype wire

[rtl/pfaa_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module pfaa_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/pfaa_locate.sv]
// Entry locator: bit position, word pair, bank addresses and range check.
// Depends on pfaa_pkg.
`default_nettype none

module pfaa_locate (
    input  wire logic [pfaa_pkg::INDEX_W-1:0] entry_index,
    input  wire logic [pfaa_pkg::EW_W-1:0]    entry_width,
    input  wire logic [pfaa_pkg::EC_W-1:0]    entry_count,
    output pfaa_pkg::loc_t                    loc
);
    import pfaa_pkg::*;

    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] end_bit;
    logic [POS_W-1:0] word;
    logic [POS_W-1:0] last;
    logic [POS_W-1:0] word_inc;

    always_comb
    begin
        pos      = POS_W'(entry_index) * POS_W'(entry_width);
        end_bit  = (entry_width == '0) ? pos : pos + POS_W'(entry_width) - POS_W'(1);
        word     = pos >> OFF_W;
        last     = end_bit >> OFF_W;
        word_inc = word + POS_W'(1);

        loc.err       = (EC_W'(entry_index) >= entry_count) || (32'(last) >= STORE_WORDS);
        loc.straddle  = (last != word);
        loc.lo_odd    = word[0];
        loc.off       = pos[OFF_W-1:0];
        loc.odd_addr  = word[1 +: BANK_AW];
        loc.even_addr = word_inc[1 +: BANK_AW];
    end

endmodule

`default_nettype wire

[rtl/pfaa_merge.sv]
// Gather and scatter of one entry across a pair of bank words.
// Depends on pfaa_pkg.
`default_nettype none

module pfaa_merge (
    input  wire logic [pfaa_pkg::WORD_BITS-1:0] even_rdata,
    input  wire logic [pfaa_pkg::WORD_BITS-1:0] odd_rdata,
    input  wire logic                           lo_odd,
    input  wire logic [pfaa_pkg::OFF_W-1:0]     off,
    input  wire logic [pfaa_pkg::EW_W-1:0]      entry_width,
    input  wire logic [pfaa_pkg::VAL_W-1:0]     write_value,
    output logic      [pfaa_pkg::VAL_W-1:0]     read_value,
    output logic      [pfaa_pkg::WORD_BITS-1:0] even_wdata,
    output logic      [pfaa_pkg::WORD_BITS-1:0] odd_wdata
);
    import pfaa_pkg::*;

    logic [VAL_W:0]        mask_full;
    logic [VAL_W-1:0]      mask;
    logic [PAIR_W-1:0]     pair;
    logic [PAIR_W-1:0]     shifted;
    logic [PAIR_W-1:0]     wide_mask;
    logic [PAIR_W-1:0]     wide_val;
    logic [PAIR_W-1:0]     merged;
    logic [WORD_BITS-1:0]  lo_new;
    logic [WORD_BITS-1:0]  hi_new;

    always_comb
    begin
        mask_full = ((VAL_W + 1)'(1) << entry_width) - (VAL_W + 1)'(1);
        mask      = mask_full[VAL_W-1:0];
        pair      = lo_odd ? {even_rdata, odd_rdata} : {odd_rdata, even_rdata};

        shifted    = pair >> off;
        read_value = shifted[VAL_W-1:0] & mask;

        wide_mask = PAIR_W'(mask) << off;
        wide_val  = PAIR_W'(write_value & mask) << off;
        merged    = (pair & ~wide_mask) | wide_val;
        lo_new    = merged[WORD_BITS-1:0];
        hi_new    = merged[PAIR_W-1:WORD_BITS];

        even_wdata = lo_odd ? hi_new : lo_new;
        odd_wdata  = lo_odd ? lo_new : hi_new;
    end

endmodule

`default_nettype wire

[rtl/packed_field_array_access_core.sv]
// Top level of the packed field array access core: APB registers, control, output stage.
// Depends on pfaa_pkg, pfaa_locate, pfaa_merge, pfaa_ram and the assertion macro header.
//
// Usage:
//   Input channel (in_valid/in_ready) carries command, entry_index and write_value.
//   Output channel (out_valid/out_ready) carries read_value and range_error, one
//   result per input transfer, in order.
//   The store is split into even and odd word banks so both words of a straddling
//   entry are read together at acceptance and written back together at completion.
//   Result path: the bank read and the item registers load at acceptance, and the
//   output register loads when the item completes, once it is free or being emptied.
//   Items do not overlap: a new one is accepted only after the previous one completes,
//   as the bank read is followed by the read-modify-write of the same bank pair.
//   Stall: while a result waits in the output register, one more item is accepted
//   and its bank read completes; it then holds until the output register frees.
//   Reset: entry_width returns to 4 and entry_count to 4096; store contents are
//   undefined until written and no clearing pass runs.
//   Configuration: write registers over APB only while the core is idle.
`default_nettype none
`include "packed_field_array_access_core_macros.svh"

module packed_field_array_access_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [pfaa_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [pfaa_pkg::PDATA_W-1:0]   pwdata,
    output logic      [pfaa_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready,

    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           command,
    input  wire logic [pfaa_pkg::INDEX_W-1:0]   entry_index,
    input  wire logic [pfaa_pkg::VAL_W-1:0]     write_value,

    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [pfaa_pkg::VAL_W-1:0]     read_value,
    output logic                                range_error
);
    import pfaa_pkg::*;

    logic [EW_W-1:0]      entry_width_reg;
    logic [EC_W-1:0]      entry_count_reg;
    reg_idx_t             reg_idx;
    logic                 cfg_wr;

    logic                 busy_reg;
    logic                 cmd_reg;
    logic [VAL_W-1:0]     wval_reg;
    loc_t                 loc_reg;
    loc_t                 loc;

    logic                 out_valid_reg;
    logic [VAL_W-1:0]     read_value_reg;
    logic                 range_error_reg;

    logic                 accept;
    logic                 complete;
    logic                 rd_fire;
    logic                 wr_fire;
    logic                 even_we;
    logic                 odd_we;
    logic [WORD_BITS-1:0] even_rdata;
    logic [WORD_BITS-1:0] odd_rdata;
    logic [WORD_BITS-1:0] even_wdata;
    logic [WORD_BITS-1:0] odd_wdata;
    logic [VAL_W-1:0]     merge_value;

    // APB register file
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[REG_IDX_LSB]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (reg_idx)
            REG_ENTRY_WIDTH: prdata = PDATA_W'(entry_width_reg);
            REG_ENTRY_COUNT: prdata = PDATA_W'(entry_count_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_width_reg <= ENTRY_WIDTH_RESET;
            entry_count_reg <= ENTRY_COUNT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_ENTRY_WIDTH: entry_width_reg <= pwdata[EW_W-1:0];
                REG_ENTRY_COUNT: entry_count_reg <= pwdata[EC_W-1:0];
                default:         ;
            endcase
        end
    end

    // Locate and issue bank reads at acceptance
    pfaa_locate u_locate (
        .entry_index (entry_index),
        .entry_width (entry_width_reg),
        .entry_count (entry_count_reg),
        .loc         (loc)
    );

    assign in_ready = !busy_reg;
    assign accept   = in_valid && in_ready;
    assign rd_fire  = accept && !loc.err;
    assign complete = busy_reg && (!out_valid_reg || out_ready);
    assign wr_fire  = complete && (cmd_reg == CMD_WRITE) && !loc_reg.err
                      && (entry_width_reg != '0);
    assign even_we  = wr_fire && (!loc_reg.lo_odd || loc_reg.straddle);
    assign odd_we   = wr_fire && (loc_reg.lo_odd || loc_reg.straddle);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (accept)
        begin
            busy_reg <= 1'b1;
        end
        else if (complete)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= command;
            wval_reg <= write_value;
            loc_reg  <= loc;
        end
    end

    pfaa_ram #(
        .DEPTH (BANK_WORDS),
        .WIDTH (WORD_BITS),
        .AW    (BANK_AW)
    ) u_even_bank (
        .clk   (clk),
        .re    (rd_fire),
        .raddr (loc.even_addr),
        .rdata (even_rdata),
        .we    (even_we),
        .waddr (loc_reg.even_addr),
        .wdata (even_wdata)
    );

    pfaa_ram #(
        .DEPTH (BANK_WORDS),
        .WIDTH (WORD_BITS),
        .AW    (BANK_AW)
    ) u_odd_bank (
        .clk   (clk),
        .re    (rd_fire),
        .raddr (loc.odd_addr),
        .rdata (odd_rdata),
        .we    (odd_we),
        .waddr (loc_reg.odd_addr),
        .wdata (odd_wdata)
    );

    pfaa_merge u_merge (
        .even_rdata  (even_rdata),
        .odd_rdata   (odd_rdata),
        .lo_odd      (loc_reg.lo_odd),
        .off         (loc_reg.off),
        .entry_width (entry_width_reg),
        .write_value (wval_reg),
        .read_value  (merge_value),
        .even_wdata  (even_wdata),
        .odd_wdata   (odd_wdata)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (complete)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (complete)
        begin
            range_error_reg <= loc_reg.err;
            read_value_reg  <= (loc_reg.err || (cmd_reg == CMD_WRITE)) ? '0 : merge_value;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_value  = read_value_reg;
    assign range_error = range_error_reg;

    `PFAA_ASSERT_NXT(a_accept_busy, accept, busy_reg, "accepted transfer did not start work")
    `PFAA_ASSERT_NXT(a_complete_out, complete, out_valid_reg, "completed item lost its result")
    `PFAA_ASSERT_IMP(a_write_owner, even_we || odd_we, busy_reg && (cmd_reg == CMD_WRITE),
                     "bank write outside a write item")
    `PFAA_ASSERT_IMP(a_straddle_pair, wr_fire && loc_reg.straddle, even_we && odd_we,
                     "straddling write did not update both banks")

endmodule

`default_nettype wire

[dv/packed_field_array_access_core_test.sv]
`timescale 1ns / 100ps
// Testbench for packed_field_array_access_core: directed and random entry reads and writes,
// checked against an in-bench copy of the packed word store, across APB layout changes.
// Depends on pfaa_pkg and the core RTL.

module packed_field_array_access_core_test;

    import pfaa_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int WINDOW      = 48;

    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        logic             range_error;
    } access_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 in_valid;
    logic                 in_ready;
    logic                 command;
    logic [INDEX_W-1:0]   entry_index;
    logic [VAL_W-1:0]     write_value;
    logic                 out_valid;
    logic                 out_ready;
    logic [VAL_W-1:0]     read_value;
    logic                 range_error;

    bit [WORD_BITS-1:0]   mirror_words [STORE_WORDS];
    bit [WORD_BITS-1:0]   written_bits [STORE_WORDS];
    logic [EW_W-1:0]      cfg_width = ENTRY_WIDTH_RESET;
    logic [EC_W-1:0]      cfg_count = ENTRY_COUNT_RESET;

    access_result_t       pending_results [$];
    int                   issued_count = 0;
    int                   returned_count = 0;
    int                   fail_count = 0;
    int                   cycle_count = 0;
    int                   send_idle_pct = 32;
    int                   recv_idle_pct = 32;
    int                   hold_orders = 0;
    int                   hold_seen = 0;
    int                   hold_left = 0;

    packed_field_array_access_core u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void note_failure(string what, logic [31:0] want, logic [31:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch on %s at %0t: expected %0h, got %0h", what, $time, want, got);
    endfunction

    function automatic bit access_rejected(logic [INDEX_W-1:0] idx);
        int unsigned pos;
        int unsigned last;
        pos = idx * cfg_width;
        last = (cfg_width != 0) ? (pos + cfg_width - 1) / WORD_BITS : pos / WORD_BITS;
        return (idx >= cfg_count) || (last >= STORE_WORDS);
    endfunction

    function automatic logic [PAIR_W-1:0] entry_span(input logic [INDEX_W-1:0] idx,
                                                     output int unsigned word,
                                                     output int unsigned off);
        int unsigned pos;
        pos = idx * cfg_width;
        word = pos / WORD_BITS;
        off = pos % WORD_BITS;
        return ((PAIR_W'(1) << cfg_width) - PAIR_W'(1)) << off;
    endfunction

    function automatic logic [PAIR_W-1:0] mirror_pair(int unsigned word);
        logic [WORD_BITS-1:0] upper;
        upper = '0;
        if (word + 1 < STORE_WORDS)
            upper = mirror_words[word + 1];
        return {upper, mirror_words[word]};
    endfunction

    function automatic logic [PAIR_W-1:0] written_pair(int unsigned word);
        logic [WORD_BITS-1:0] upper;
        upper = '0;
        if (word + 1 < STORE_WORDS)
            upper = written_bits[word + 1];
        return {upper, written_bits[word]};
    endfunction

    function automatic access_result_t predict_access(logic cmd, logic [INDEX_W-1:0] idx,
                                                      logic [VAL_W-1:0] val);
        access_result_t res;
        int unsigned word;
        int unsigned off;
        logic [PAIR_W-1:0] span;
        logic [PAIR_W-1:0] pair;
        res = '0;
        if (access_rejected(idx))
        begin
            res.range_error = 1'b1;
            return res;
        end
        span = entry_span(idx, word, off);
        pair = mirror_pair(word);
        if (cmd == CMD_READ)
            res.read_value = VAL_W'((pair & span) >> off);
        else
        begin
            pair = (pair & ~span) | ((PAIR_W'(val) << off) & span);
            mirror_words[word] = pair[WORD_BITS-1:0];
            if (word + 1 < STORE_WORDS)
                mirror_words[word + 1] = pair[PAIR_W-1:WORD_BITS];
        end
        return res;
    endfunction

    always @(posedge clk)
    begin : check_results
        access_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                returned_count++;
                if (pending_results.size() == 0)
                    note_failure("unexpected result", 32'h0, {read_value, range_error});
                else
                begin
                    want = pending_results.pop_front();
                    if (read_value !== want.read_value)
                        note_failure("read_value", want.read_value, read_value);
                    if (range_error !== want.range_error)
                        note_failure("range_error", want.range_error, range_error);
                end
            end
            if (in_valid && in_ready)
                pending_results.push_back(predict_access(command, entry_index, write_value));
        end
    end

    always @(posedge clk)
    begin
        if (hold_seen != hold_orders)
        begin
            hold_seen = hold_orders;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_access(input logic cmd, input logic [INDEX_W-1:0] idx,
                               input logic [VAL_W-1:0] val);
        int unsigned word;
        int unsigned off;
        logic [PAIR_W-1:0] span;
        if (!access_rejected(idx))
        begin
            span = entry_span(idx, word, off);
            if (cmd == CMD_READ && (written_pair(word) & span) != span)
                cmd = CMD_WRITE;
            if (cmd == CMD_WRITE)
            begin
                written_bits[word] |= span[WORD_BITS-1:0];
                if (word + 1 < STORE_WORDS)
                    written_bits[word + 1] |= span[PAIR_W-1:WORD_BITS];
            end
        end
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        entry_index <= idx;
        write_value <= val;
        do
            @(posedge clk);
        while (!in_ready);
        issued_count++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (returned_count != issued_count);
    endtask

    task automatic apb_transfer(input logic wr, input reg_idx_t r, input logic [PDATA_W-1:0] data,
                                output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= PADDR_W'(int'(r) << REG_IDX_LSB);
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_registers();
        logic [PDATA_W-1:0] rdata;
        apb_transfer(1'b0, REG_ENTRY_WIDTH, '0, rdata);
        if (rdata[EW_W-1:0] !== cfg_width)
            note_failure("entry_width register", cfg_width, rdata);
        apb_transfer(1'b0, REG_ENTRY_COUNT, '0, rdata);
        if (rdata[EC_W-1:0] !== cfg_count)
            note_failure("entry_count register", cfg_count, rdata);
    endtask

    // Upper pwdata bits carry noise; only the register's own bits count.
    task automatic set_layout(input logic [EW_W-1:0] width, input logic [EC_W-1:0] count);
        logic [PDATA_W-1:0] rdata;
        drain_results();
        repeat (3) @(posedge clk);
        apb_transfer(1'b1, REG_ENTRY_WIDTH, ($urandom & ~32'h1F) | PDATA_W'(width), rdata);
        cfg_width = width;
        apb_transfer(1'b1, REG_ENTRY_COUNT, ($urandom & ~32'h1FFFF) | PDATA_W'(count), rdata);
        cfg_count = count;
        check_registers();
    endtask

    task automatic run_traffic(input int n_items);
        int unsigned fit;
        int unsigned cap;
        int unsigned base;
        int unsigned idx;
        int unsigned roll;
        logic [VAL_W-1:0] val;
        fit = (cfg_width == 0) ? 65536 : (STORE_WORDS * WORD_BITS) / cfg_width;
        cap = (cfg_count < fit) ? cfg_count : fit;
        if (cap > 65536)
            cap = 65536;
        base = (cap > WINDOW) ? $urandom_range(cap - WINDOW) : 0;
        repeat (n_items)
        begin
            roll = $urandom_range(99);
            if (cap != 0 && roll < 55)
                idx = base + $urandom_range(WINDOW - 1);
            else if (cap != 0 && roll < 75)
                idx = $urandom_range(cap - 1);
            else if (roll < 88)
                idx = cap + $urandom_range(3) - 2;
            else
                idx = $urandom_range(16'hFFFF);
            case ($urandom_range(9))
                0: val = '1;
                1: val = '0;
                default: val = VAL_W'($urandom);
            endcase
            send_access($urandom_range(1) ? CMD_WRITE : CMD_READ, INDEX_W'(idx), val);
        end
    endtask

    task automatic run_phase(input logic [EW_W-1:0] width, input logic [EC_W-1:0] count,
                             input int n_items);
        set_layout(width, count);
        run_traffic(n_items);
    endtask

    task automatic test_register_reset();
        check_registers();
    endtask

    task automatic test_default_layout();
        send_access(CMD_WRITE, 16'd0, 31'h7FFF_FFFF);
        send_access(CMD_WRITE, 16'd1, 31'h0);
        send_access(CMD_READ, 16'd0, 31'h0);
        send_access(CMD_READ, 16'd1, 31'h7FFF_FFFF);
        send_access(CMD_WRITE, 16'd4095, 31'h5AA5_5AA5);
        send_access(CMD_READ, 16'd4095, 31'h0);
        send_access(CMD_READ, 16'd4096, 31'h0);
        send_access(CMD_WRITE, 16'hFFFF, 31'h7FFF_FFFF);
    endtask

    task automatic test_width_extremes();
        set_layout(5'd31, 17'd65536);
        send_access(CMD_WRITE, 16'd2, 31'h7FFF_FFFF);
        send_access(CMD_WRITE, 16'd1, 31'h2AAA_AAAA);
        send_access(CMD_WRITE, 16'd3, 31'h0);
        send_access(CMD_READ, 16'd2, 31'h0);
        send_access(CMD_READ, 16'd1, 31'h0);
        send_access(CMD_WRITE, 16'd2113, 31'h7FFF_FFFF);
        send_access(CMD_READ, 16'd2113, 31'h0);
        send_access(CMD_WRITE, 16'd2114, 31'h1234_5678);
        send_access(CMD_READ, 16'd2114, 31'h0);
        set_layout(5'd1, 17'h1FFFF);
        send_access(CMD_WRITE, 16'hFFFF, 31'h1);
        send_access(CMD_READ, 16'hFFFF, 31'h0);
        send_access(CMD_WRITE, 16'hFFFE, 31'h7FFF_FFFE);
        send_access(CMD_READ, 16'hFFFE, 31'h0);
        set_layout(5'd0, 17'd65536);
        send_access(CMD_WRITE, 16'd9, 31'h7FFF_FFFF);
        send_access(CMD_READ, 16'd9, 31'h0);
        set_layout(5'd5, 17'd0);
        send_access(CMD_READ, 16'd0, 31'h0);
        send_access(CMD_WRITE, 16'd0, 31'h7FFF_FFFF);
    endtask

    task automatic test_random_layouts();
        run_phase(5'd4, 17'd4096, 150);
        run_phase(5'd1, 17'd65536, 150);
        run_phase(5'd31, 17'd65536, 150);
        run_phase(5'd17, EC_W'($urandom_range(3000, 1)), 150);
        run_phase(5'd0, 17'd65536, 50);
        repeat (4)
            run_phase(EW_W'($urandom_range(30, 2)),
                      $urandom_range(1) ? 17'd65536 : EC_W'($urandom_range(131071)), 130);
        run_phase(5'd8, 17'd0, 20);
    endtask

    task automatic test_full_rate();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(5'd16, 17'd65536, 200);
        send_idle_pct = 32;
        recv_idle_pct = 32;
    endtask

    task automatic test_output_stall();
        set_layout(5'd12, 17'd65536);
        send_idle_pct = 0;
        hold_orders++;
        run_traffic(40);
        send_idle_pct = 32;
    endtask

    task automatic test_sender_pause();
        run_traffic(30);
        drain_results();
        run_traffic(30);
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        in_valid    <= 1'b0;
        command     <= CMD_READ;
        entry_index <= '0;
        write_value <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_reset();
        test_default_layout();
        test_width_extremes();
        test_random_layouts();
        test_full_rate();
        test_output_stall();
        test_sender_pause();
        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
